// ===== rtl/cidram_pkg.sv =====
// ----------------------------------------------------------------------------
// cidram_pkg
// Shared types, codes and helpers for the CIDR allowlist matcher.
// ----------------------------------------------------------------------------
package cidram_pkg;

	// Command codes carried in the low bits of s_tuser
	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

	localparam int IDX_W  = 4;
	localparam int HALF_W = 64;
	localparam int ADDR_W = 128;
	localparam int PFX_W  = 8;

	localparam logic [PFX_W-1:0] V4_MAX_PREFIX = 8'd32;
	localparam logic [PFX_W-1:0] V6_MAX_PREFIX = 8'd128;

	// Stream widths
	localparam int S_TDATA_W = 144;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 8;

	// Rule store word: {is_v6, network[127:0], prefix[7:0]}
	localparam int RULE_W = 1 + ADDR_W + PFX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} st_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // capture the accepted item, clear the scan
		logic exec;       // apply a write or remove
		logic scan_step;  // read one slot, advance the pointer
		logic out_load;   // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_check;
		logic ptr_last;
		logic out_free;
	} dp_stat_t;

	// Keep the leading plen bits of a 128-bit value; bit 127 leads
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		for (int b = 0; b < ADDR_W; b++) begin
			m[b] = ({1'b0, plen} + 9'(b)) >= 9'(ADDR_W);
		end
		return m;
	endfunction

endpackage

// ===== rtl/cidr_allowlist_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// cidr_allowlist_matcher_unit
// CIDR allowlist: store IPv4/IPv6 prefix rules and check addresses.
// ----------------------------------------------------------------------------
// One item in, one result item out. A write stores a rule (family, network
// masked to its prefix, prefix length) in a slot; a prefix over 32 (IPv4) or
// 128 (IPv6) is rejected with status 1 and the slot is left as it was. A
// remove clears a slot. A write or remove to a slot at or beyond RULE_SLOTS
// leaves the rules alone. A check reports allowed when no slot is valid or
// when a valid slot of the same family agrees with the address in its
// leading prefix bits. Command 3 returns allowed 0, status 0. Timing: one
// item is in flight at a time. A check walks the rule store through its
// single read port, one slot per cycle, and then drains the registered
// read before its result is formed. The result waits in an output
// register, so the next item is taken while the previous result is still
// unclaimed. The rule store needs no clearing pass: only slots marked
// valid, which are flip-flops cleared by reset, are ever compared.
// ----------------------------------------------------------------------------
module cidr_allowlist_matcher_unit #(
	parameter int RULE_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// entry_index[3:0], address_hi[67:4], address_lo[131:68],
	// prefix_len[139:132], zero fill[143:140]
	input  logic [cidram_pkg::S_TDATA_W-1:0]    s_tdata,
	// command[1:0], is_v6[2]
	input  logic [cidram_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// allowed[0], status[1], zero fill[7:2]
	output logic [cidram_pkg::M_TDATA_W-1:0]    m_tdata
);

	import cidram_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each item: capture, update or walk, hand off the result
	cidram_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Hold the rules, compare one slot per cycle, register the result
	cidram_dp #(
		.RULE_SLOTS(RULE_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ===== rtl/cidram_ram.sv =====
// ----------------------------------------------------------------------------
// cidram_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cidram_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cidram_dp.sv =====
// ----------------------------------------------------------------------------
// cidram_dp
// Datapath: item capture, rule store, valid bits, slot compare and result.
// ----------------------------------------------------------------------------
module cidram_dp #(
	parameter int RULE_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cidram_pkg::dp_cmd_t                 cmd,
	output cidram_pkg::dp_stat_t                stat,
	input  logic [cidram_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [cidram_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cidram_pkg::M_TDATA_W-1:0]    m_tdata
);

	import cidram_pkg::*;

	localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

	// Captured item
	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              v6_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PFX_W-1:0]  plen_q;

	logic [RULE_SLOTS-1:0] valid_q;
	logic [AW-1:0]         ptr_q;
	logic                  cmp_en_s1;
	logic                  cmp_vld_s1;
	logic                  any_q;
	logic                  hit_q;
	logic                  m_tvalid_q;
	logic                  allowed_q;
	logic                  status_q;

	logic              plen_ok;
	logic              in_range;
	logic [AW-1:0]     waddr;
	logic              rule_we;
	logic [RULE_W-1:0] rule_wdata;
	logic [RULE_W-1:0] rule_rdata;
	logic              r_v6;
	logic [ADDR_W-1:0] r_net;
	logic [PFX_W-1:0]  r_pfx;
	logic              slot_match;

	assign plen_ok  = v6_q ? (plen_q <= V6_MAX_PREFIX) : (plen_q <= V4_MAX_PREFIX);
	assign in_range = ({5'd0, idx_q} < 9'(RULE_SLOTS));
	assign waddr    = AW'({5'd0, idx_q});

	assign rule_we    = cmd.exec && (cmd_q == CMD_WRITE) && plen_ok && in_range;
	assign rule_wdata = {v6_q, addr_q & prefix_mask(plen_q), plen_q};

	cidram_ram #(
		.WIDTH(RULE_W),
		.DEPTH(RULE_SLOTS),
		.AW   (AW)
	) u_rules (
		.clk  (clk),
		.we   (rule_we),
		.waddr(waddr),
		.wdata(rule_wdata),
		.raddr(ptr_q),
		.rdata(rule_rdata)
	);

	assign r_v6  = rule_rdata[RULE_W-1];
	assign r_net = rule_rdata[RULE_W-2:PFX_W];
	assign r_pfx = rule_rdata[PFX_W-1:0];

	assign slot_match = (r_v6 == v6_q) && (((addr_q ^ r_net) & prefix_mask(r_pfx)) == '0);

	// Capture payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= s_tdata[3:0];
			addr_q <= {s_tdata[67:4], s_tdata[131:68]};
			plen_q <= s_tdata[139:132];
			cmd_q  <= s_tuser[1:0];
			v6_q   <= s_tuser[2];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.exec && in_range) begin
			if (rule_we) begin
				valid_q[waddr] <= 1'b1;
			end else if (cmd_q == CMD_REMOVE) begin
				valid_q[waddr] <= 1'b0;
			end
		end
	end

	// Slot walk and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			cmp_en_s1  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			any_q      <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			cmp_en_s1  <= cmd.scan_step;
			cmp_vld_s1 <= valid_q[ptr_q];
			if (cmd.load) begin
				ptr_q <= '0;
				any_q <= 1'b0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					ptr_q <= ptr_q + AW'(1);
				end
				if (cmp_en_s1 && cmp_vld_s1) begin
					any_q <= 1'b1;
					if (slot_match) begin
						hit_q <= 1'b1;
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			allowed_q <= (cmd_q == CMD_CHECK) && (!any_q || hit_q);
			status_q  <= (cmd_q == CMD_WRITE) && !plen_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, status_q, allowed_q};

	assign stat.is_check = (cmd_q == CMD_CHECK);
	assign stat.ptr_last = (ptr_q == AW'(RULE_SLOTS - 1));
	assign stat.out_free = !m_tvalid_q || m_tready;

`ifndef ASSERT_OFF
	a_we_prefix_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rule_we |-> (plen_q <= V6_MAX_PREFIX) && (v6_q || plen_q <= V4_MAX_PREFIX))
		else $error("rule written with an out-of-range prefix");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(allowed_q && status_q))
		else $error("result both allowed and rejected");

	a_no_cmp_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !cmp_en_s1 && !cmd.scan_step)
		else $error("rule update overlaps a slot walk");
`endif

endmodule

// ===== rtl/cidram_ctrl.sv =====
// ----------------------------------------------------------------------------
// cidram_ctrl
// Controller: sequences capture, rule update, slot walk and result handoff.
// ----------------------------------------------------------------------------
module cidram_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  cidram_pkg::dp_stat_t stat,
	output cidram_pkg::dp_cmd_t  cmd
);

	import cidram_pkg::*;

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = stat.is_check ? ST_SCAN : ST_RESULT;
			end
			ST_SCAN: begin
				if (stat.ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.exec      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_EXEC: begin
				cmd.exec = !stat.is_check;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_RESULT: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !stat.out_free) |=> state_q == ST_RESULT)
		else $error("result dropped while output register busy");

	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !stat.ptr_last) |=> state_q == ST_SCAN)
		else $error("slot walk ended early");
`endif

endmodule
